/* hw/rtl/tie_pkg.sv */
// Shared types and constants of the tiny ISA execute unit.
`timescale 1ns / 1ps

package tie_pkg;

  typedef enum logic [2:0] {
    OP_MOV  = 3'd0,
    OP_ADD  = 3'd1,
    OP_ADDI = 3'd2,
    OP_CMP  = 3'd3,
    OP_JE   = 3'd4,
    OP_JMP  = 3'd5,
    OP_LD   = 3'd6,
    OP_ST   = 3'd7
  } op_e;

  localparam logic [5:0] BASE_COST = 6'd1;
  localparam logic [5:0] HIT_COST  = 6'd2;
  localparam logic [5:0] MISS_COST = 6'd45;

  typedef struct packed {
    logic       en;
    logic       is_ld;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

endpackage

/* hw/rtl/tie_ram.sv */
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module tie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tie_regfile.sv */
// Register file with two registered read ports, reset-valid bits and write bypass.
`timescale 1ns / 1ps

module tie_regfile #(
  parameter int NUM_REGS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rd_en_i,
  input  logic [2:0] rd_a_idx_i,
  input  logic [2:0] rd_b_idx_i,
  input  logic       wr_en_i,
  input  logic [2:0] wr_idx_i,
  input  logic [7:0] wr_data_i,
  output logic [7:0] a_val_o,
  output logic [7:0] b_val_o
);

  localparam int RegAw = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int RegN  = 1 << RegAw;

  logic [RegAw-1:0] a_addr, b_addr, w_addr;
  logic             a_ok, b_ok, w_ok, w_en;
  logic [RegN-1:0]  vld_q;
  logic             a_ok_q, b_ok_q, a_vld_q, b_vld_q, a_fwd_q, b_fwd_q;
  logic [7:0]       a_fwd_data_q, b_fwd_data_q;
  logic [7:0]       a_rdata, b_rdata;

  assign a_ok   = 32'(rd_a_idx_i) < NUM_REGS;
  assign b_ok   = 32'(rd_b_idx_i) < NUM_REGS;
  assign w_ok   = 32'(wr_idx_i) < NUM_REGS;
  assign a_addr = RegAw'(rd_a_idx_i);
  assign b_addr = RegAw'(rd_b_idx_i);
  assign w_addr = RegAw'(wr_idx_i);
  assign w_en   = wr_en_i && w_ok;

  tie_ram #(.WIDTH(8), .DEPTH(RegN)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (w_en),
    .waddr_i (w_addr),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (a_addr),
    .rdata_o (a_rdata)
  );

  tie_ram #(.WIDTH(8), .DEPTH(RegN)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (w_en),
    .waddr_i (w_addr),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (b_addr),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      a_ok_q  <= 1'b0;
      b_ok_q  <= 1'b0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      a_fwd_q <= 1'b0;
      b_fwd_q <= 1'b0;
    end else begin
      if (w_en) begin
        vld_q[w_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        a_ok_q  <= a_ok;
        b_ok_q  <= b_ok;
        a_vld_q <= vld_q[a_addr];
        b_vld_q <= vld_q[b_addr];
        a_fwd_q <= w_en && (w_addr == a_addr);
        b_fwd_q <= w_en && (w_addr == b_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      a_fwd_data_q <= wr_data_i;
      b_fwd_data_q <= wr_data_i;
    end
  end

  assign a_val_o = !a_ok_q ? 8'd0 : a_fwd_q ? a_fwd_data_q : a_vld_q ? a_rdata : 8'd0;
  assign b_val_o = !b_ok_q ? 8'd0 : b_fwd_q ? b_fwd_data_q : b_vld_q ? b_rdata : 8'd0;

endmodule

/* hw/rtl/tie_dmem.sv */
// Data memory with per-byte touched bits and hit detection.
`timescale 1ns / 1ps

module tie_dmem
  import tie_pkg::*;
#(
  parameter int MEM_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output logic     hit_o,
  output logic [7:0] rdata_o
);

  localparam int MemAw = $clog2(MEM_DEPTH);

  function automatic logic [MemAw-1:0] mod_depth(input logic [7:0] v);
    logic [11:0] r;
    r = 12'(v);
    for (int k = 3; k >= 0; k--) begin
      if (r >= 12'(MEM_DEPTH << k)) begin
        r = r - 12'(MEM_DEPTH << k);
      end
    end
    return MemAw'(r);
  endfunction

  logic [MemAw-1:0]     addr;
  logic [MEM_DEPTH-1:0] touched_q;
  logic                 hit, we, re;

  assign addr  = mod_depth(req_i.addr);
  assign hit   = touched_q[addr];
  assign we    = req_i.en && (!req_i.is_ld || !hit);
  assign re    = req_i.en && req_i.is_ld && hit;
  assign hit_o = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q <= '0;
    end else if (req_i.en) begin
      touched_q[addr] <= 1'b1;
    end
  end

  tie_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (req_i.wdata),
    .re_i    (re),
    .raddr_i (addr),
    .rdata_o (rdata_o)
  );

endmodule

/* hw/rtl/tiny_isa_execute_unit.sv */
// Top level of the tiny ISA execute unit: decode, execute, counters and result register.
//
//   channel  direction  handshake                    payload
//   cfg      in         cfg_valid_i / cfg_ready_o    cfg_program_base_i
//   in       in         in_valid_i / in_stall_o      op, reg_a, reg_b, imm, target
//   out      out        out_valid_o / out_stall_i    next_index .. ldst_total
//
// One instruction per cycle unless a stalled result or an LD holds the input; a request
// passes through the input register (register file read) and then the result register.
// LD blocks the input while it executes: the data memory read is registered
// and its register write lands the cycle after execute.
// Reset clears registers, flag, touched bits, index and totals; no clearing pass.
// A stalled result holds; the input register still takes one more request.
`timescale 1ns / 1ps

module tiny_isa_execute_unit
  import tie_pkg::*;
#(
  parameter int NUM_REGS  = 6,
  parameter int MEM_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_program_base_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        op_i,
  input  logic [2:0]        reg_a_i,
  input  logic [2:0]        reg_b_i,
  input  logic signed [7:0] imm_i,
  input  logic [15:0]       target_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       next_index_o,
  output logic              jump_taken_o,
  output logic [5:0]        step_cycles_o,
  output logic              mem_hit_o,
  output logic [31:0]       instr_total_o,
  output logic [31:0]       cycle_total_o,
  output logic [31:0]       hit_total_o,
  output logic [31:0]       ldst_total_o
);

  logic [15:0] base_q;
  logic        s1_valid_q;
  op_e         s1_op_q;
  logic [2:0]  s1_ra_q;
  logic [7:0]  s1_imm_q;
  logic [15:0] s1_target_q;

  logic        eq_q, eq_d;
  logic [15:0] index_q, index_d;
  logic [31:0] instr_q, cycles_q, hits_q, ldst_q;
  logic        res_valid_q, res_jump_q, res_hit_q;
  logic [5:0]  res_cycles_q;
  logic        ld_q, ld_hit_q;
  logic [2:0]  ld_ra_q;

  logic        accept, exec_go, s1_is_ld, s1_is_mem;
  logic [7:0]  a_val, b_val;
  logic        wb_en;
  logic [7:0]  wb_data;
  logic        jump;
  logic [5:0]  cost;
  logic        hit;
  logic        dmem_hit;
  logic [7:0]  dmem_rdata;
  mem_req_t    mem_req;
  logic        rf_we;
  logic [2:0]  rf_widx;
  logic [7:0]  rf_wdata;

  assign cfg_ready_o = 1'b1;
  assign s1_is_ld    = s1_op_q == OP_LD;
  assign s1_is_mem   = (s1_op_q == OP_LD) || (s1_op_q == OP_ST);
  assign exec_go     = s1_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && (!exec_go || s1_is_ld);
  assign accept      = in_valid_i && !in_stall_o;

  assign mem_req.en    = exec_go && s1_is_mem;
  assign mem_req.is_ld = s1_is_ld;
  assign mem_req.addr  = s1_is_ld ? b_val : a_val;
  assign mem_req.wdata = s1_is_ld ? 8'd0 : b_val;

  always_comb begin
    wb_en   = 1'b0;
    wb_data = a_val;
    eq_d    = eq_q;
    jump    = 1'b0;
    cost    = BASE_COST;
    hit     = 1'b0;
    unique case (s1_op_q)
      OP_MOV: begin
        wb_en   = 1'b1;
        wb_data = s1_imm_q;
      end
      OP_ADD: begin
        wb_en   = 1'b1;
        wb_data = a_val + b_val;
      end
      OP_ADDI: begin
        wb_en   = 1'b1;
        wb_data = a_val + s1_imm_q;
      end
      OP_CMP: begin
        eq_d = a_val == b_val;
      end
      OP_JE: begin
        jump = eq_q;
        eq_d = 1'b0;
      end
      OP_JMP: begin
        jump = 1'b1;
      end
      OP_LD, OP_ST: begin
        hit  = dmem_hit;
        cost = dmem_hit ? HIT_COST : MISS_COST;
      end
    endcase
    index_d = jump ? (s1_target_q - base_q) : (index_q + 16'd1);
  end

  assign rf_we    = ld_q || (exec_go && wb_en);
  assign rf_widx  = ld_q ? ld_ra_q : s1_ra_q;
  assign rf_wdata = ld_q ? (ld_hit_q ? dmem_rdata : 8'd0) : wb_data;

  tie_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_a_idx_i (reg_a_i),
    .rd_b_idx_i (reg_b_i),
    .wr_en_i    (rf_we),
    .wr_idx_i   (rf_widx),
    .wr_data_i  (rf_wdata),
    .a_val_o    (a_val),
    .b_val_o    (b_val)
  );

  tie_dmem #(.MEM_DEPTH(MEM_DEPTH)) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .hit_o   (dmem_hit),
    .rdata_o (dmem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_op_q     <= OP_MOV;
      eq_q        <= 1'b0;
      index_q     <= '0;
      instr_q     <= '0;
      cycles_q    <= '0;
      hits_q      <= '0;
      ldst_q      <= '0;
      res_valid_q <= 1'b0;
      ld_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_program_base_i;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_op_q    <= op_e'(op_i);
      end else if (exec_go) begin
        s1_valid_q <= 1'b0;
      end
      ld_q <= exec_go && s1_is_ld;
      if (exec_go) begin
        eq_q        <= eq_d;
        index_q     <= index_d;
        instr_q     <= instr_q + 32'd1;
        cycles_q    <= cycles_q + 32'(cost);
        hits_q      <= hits_q + 32'(hit);
        ldst_q      <= ldst_q + 32'(s1_is_mem);
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ra_q     <= reg_a_i;
      s1_imm_q    <= $unsigned(imm_i);
      s1_target_q <= target_i;
    end
    if (exec_go) begin
      res_jump_q   <= jump;
      res_hit_q    <= hit;
      res_cycles_q <= cost;
      ld_ra_q      <= s1_ra_q;
      ld_hit_q     <= dmem_hit;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign next_index_o  = index_q;
  assign jump_taken_o  = res_jump_q;
  assign step_cycles_o = res_cycles_q;
  assign mem_hit_o     = res_hit_q;
  assign instr_total_o = instr_q;
  assign cycle_total_o = cycles_q;
  assign hit_total_o   = hits_q;
  assign ldst_total_o  = ldst_q;

  // no request in execute while a load writes back
  a_ld_wb_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_q |-> !s1_valid_q)
    else $error("execute overlaps load write-back");

  a_instr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> instr_total_o == $past(instr_total_o) + 32'd1)
    else $error("instruction total did not advance");

  a_hit_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mem_hit_o) |-> step_cycles_o == HIT_COST)
    else $error("hit with wrong cost");

  a_jump_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(jump_taken_o && mem_hit_o))
    else $error("jump and memory hit together");

  a_ld_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && s1_is_ld) |=> !s1_valid_q)
    else $error("request taken behind a load");

endmodule
